### hw/rtl/nsas_pkg.sv
package nsas_pkg;

    localparam int DATA_W        = 32;
    localparam int POS_W         = 10;
    localparam int ACT_W         = 2;
    localparam int DEPTH_DEFAULT = 1024;

    typedef enum logic [ACT_W-1:0] {
        ACT_APPEND = 2'd0,
        ACT_QUERY  = 2'd1,
        ACT_CLEAR  = 2'd2
    } t_action;

    typedef enum logic [2:0] {
        S_IDLE,
        S_STEP,
        S_MID,
        S_BELOW,
        S_ABOVE,
        S_DONE
    } t_state;

endpackage

### hw/rtl/nearly_sorted_array_search_unit.sv
// Search unit for a nearly sorted store of signed 32-bit words, where each element sits at
// most one slot from its sorted place. An append request writes the next entry (a full
// store drops it and sets the sticky overflow flag), a clear request empties the store,
// and a query request runs a binary search that probes mid, mid-1 and mid+1 and answers
// with found, position and the overflow flag. All words live in one synchronous memory
// with a single read port, so each search step first issues the read of mid and then
// reads the probed words one at a time. One request is worked on at a time; the result
// waits in an output register while the next request is taken.
module nearly_sorted_array_search_unit #(
    parameter int DEPTH = nsas_pkg::DEPTH_DEFAULT
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_ready,
    input  logic [nsas_pkg::ACT_W-1:0]         i_action,
    input  logic signed [nsas_pkg::DATA_W-1:0] i_value,
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output logic                               o_found,
    output logic [nsas_pkg::POS_W-1:0]         o_position,
    output logic                               o_overflowed
);
    import nsas_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam int LW = CW + 2;

    logic signed [DATA_W-1:0] mem [DEPTH];

    t_state r_state, n_state;
    logic [CW-1:0]            r_count, n_count;
    logic                     r_overflow, n_overflow;
    logic signed [DATA_W-1:0] r_target, n_target;
    logic signed [LW-1:0]     r_lo, n_lo;
    logic signed [LW-1:0]     r_hi, n_hi;
    logic signed [LW-1:0]     r_mid, n_mid;
    logic                     r_gt, n_gt;
    logic                     r_found, n_found;
    logic signed [LW-1:0]     r_hit, n_hit;
    logic                     r_out_valid, n_out_valid;
    logic                     r_o_found, n_o_found;
    logic [POS_W-1:0]         r_o_pos, n_o_pos;
    logic                     r_o_ovf, n_o_ovf;
    logic signed [DATA_W-1:0] r_rdata;

    logic          mem_we;
    logic [AW-1:0] wr_addr;
    logic [AW-1:0] rd_addr;
    logic          in_fire;
    logic signed [LW-1:0] mid_c;
    logic signed [LW-1:0] mid_dn;
    logic signed [LW-1:0] mid_up;
    logic          gt_now;

    assign o_in_ready   = (r_state == S_IDLE);
    assign in_fire      = i_in_valid && o_in_ready;
    assign o_out_valid  = r_out_valid;
    assign o_found      = r_o_found;
    assign o_position   = r_o_pos;
    assign o_overflowed = r_o_ovf;

    assign mid_c  = r_lo + ((r_hi - r_lo) >>> 1);
    assign mid_dn = r_mid - LW'(1);
    assign mid_up = r_mid + LW'(1);
    assign gt_now = (r_target > r_rdata);

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[wr_addr] <= i_value;
        end
        r_rdata <= mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_overflow  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_count     <= n_count;
            r_overflow  <= n_overflow;
            r_out_valid <= n_out_valid;
        end
        r_target  <= n_target;
        r_lo      <= n_lo;
        r_hi      <= n_hi;
        r_mid     <= n_mid;
        r_gt      <= n_gt;
        r_found   <= n_found;
        r_hit     <= n_hit;
        r_o_found <= n_o_found;
        r_o_pos   <= n_o_pos;
        r_o_ovf   <= n_o_ovf;
    end

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_overflow  = r_overflow;
        n_target    = r_target;
        n_lo        = r_lo;
        n_hi        = r_hi;
        n_mid       = r_mid;
        n_gt        = r_gt;
        n_found     = r_found;
        n_hit       = r_hit;
        n_out_valid = r_out_valid;
        n_o_found   = r_o_found;
        n_o_pos     = r_o_pos;
        n_o_ovf     = r_o_ovf;
        mem_we      = 1'b0;
        wr_addr     = r_count[AW-1:0];
        rd_addr     = r_mid[AW-1:0];

        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (in_fire) begin
                    priority if (i_action == ACT_APPEND) begin
                        if (r_count < CW'(DEPTH)) begin
                            mem_we  = 1'b1;
                            n_count = r_count + CW'(1);
                        end else begin
                            n_overflow = 1'b1;
                        end
                    end else if (i_action == ACT_CLEAR) begin
                        n_count = '0;
                    end else if (i_action == ACT_QUERY) begin
                        n_target = i_value;
                        n_lo     = '0;
                        n_hi     = LW'(r_count) - LW'(1);
                        n_state  = S_STEP;
                    end else begin
                        n_state = S_IDLE;
                    end
                end
            end
            S_STEP: begin
                if (r_lo > r_hi) begin
                    n_found = 1'b0;
                    n_hit   = '0;
                    n_state = S_DONE;
                end else begin
                    rd_addr = mid_c[AW-1:0];
                    n_mid   = mid_c;
                    n_state = S_MID;
                end
            end
            S_MID: begin
                n_gt = gt_now;
                if (r_rdata == r_target) begin
                    n_found = 1'b1;
                    n_hit   = r_mid;
                    n_state = S_DONE;
                end else if (mid_dn >= r_lo) begin
                    rd_addr = mid_dn[AW-1:0];
                    n_state = S_BELOW;
                end else if (mid_up <= r_hi) begin
                    rd_addr = mid_up[AW-1:0];
                    n_state = S_ABOVE;
                end else begin
                    if (gt_now) begin
                        n_lo = r_mid + LW'(2);
                    end else begin
                        n_hi = r_mid - LW'(2);
                    end
                    n_state = S_STEP;
                end
            end
            S_BELOW: begin
                if (r_rdata == r_target) begin
                    n_found = 1'b1;
                    n_hit   = mid_dn;
                    n_state = S_DONE;
                end else if (mid_up <= r_hi) begin
                    rd_addr = mid_up[AW-1:0];
                    n_state = S_ABOVE;
                end else begin
                    if (r_gt) begin
                        n_lo = r_mid + LW'(2);
                    end else begin
                        n_hi = r_mid - LW'(2);
                    end
                    n_state = S_STEP;
                end
            end
            S_ABOVE: begin
                if (r_rdata == r_target) begin
                    n_found = 1'b1;
                    n_hit   = mid_up;
                    n_state = S_DONE;
                end else begin
                    if (r_gt) begin
                        n_lo = r_mid + LW'(2);
                    end else begin
                        n_hi = r_mid - LW'(2);
                    end
                    n_state = S_STEP;
                end
            end
            S_DONE: begin
                // The result waits here until the output register is free.
                if (!r_out_valid || i_out_ready) begin
                    n_out_valid = 1'b1;
                    n_o_found   = r_found;
                    n_o_pos     = r_found ? POS_W'($unsigned(r_hit)) : '0;
                    n_o_ovf     = r_overflow;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

### test/nearly_sorted_array_search_unit_tb.sv
module nearly_sorted_array_search_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import nsas_pkg::*;

    localparam int DEPTH = DEPTH_DEFAULT;
    localparam logic [ACT_W-1:0] ACT_UNUSED = 2'd3;
    localparam logic signed [DATA_W-1:0] WORD_MIN = {1'b1, {(DATA_W-1){1'b0}}};
    localparam logic signed [DATA_W-1:0] WORD_MAX = {1'b0, {(DATA_W-1){1'b1}}};
    localparam int STALL_CYCLES = 300;
    localparam int DRAIN_CYCLES = 100;

    typedef struct {
        bit                        pause;
        logic [ACT_W-1:0]          action;
        logic signed [DATA_W-1:0]  value;
    } stim_entry;

    typedef struct {
        logic              found;
        logic [POS_W-1:0]  position;
        logic              overflowed;
    } search_answer;

    logic                      i_clk = 1'b0;
    logic                      i_rst_n = 1'b0;
    logic                      i_in_valid = 1'b0;
    logic                      o_in_ready;
    logic [ACT_W-1:0]          i_action = ACT_APPEND;
    logic signed [DATA_W-1:0]  i_value = '0;
    logic                      o_out_valid;
    logic                      i_out_ready = 1'b0;
    logic                      o_found;
    logic [POS_W-1:0]          o_position;
    logic                      o_overflowed;

    stim_entry    stim_q[$];
    search_answer pending_answers[$];
    search_answer oldest;

    // Mirror of the block's store, element count and sticky overflow flag.
    logic signed [DATA_W-1:0] model_words [0:DEPTH-1];
    int                       model_count = 0;
    logic                     model_overflow = 1'b0;

    logic signed [DATA_W-1:0] gen_set[$];
    int n_items = 0;
    int n_taken = 0;
    int n_errors = 0;
    int hold_mark = 0;
    int hold_left = 0;
    bit hold_done = 1'b0;
    bit in_fire = 1'b0;

    nearly_sorted_array_search_unit #(
        .DEPTH(DEPTH)
    ) DUT (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_action     (i_action),
        .i_value      (i_value),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_found      (o_found),
        .o_position   (o_position),
        .o_overflowed (o_overflowed)
    );

    always #5 i_clk = ~i_clk;

    // Binary search that also looks one slot either side of mid; -1 when absent.
    function automatic int probe_search(input logic signed [DATA_W-1:0] target);
        int lo;
        int hi;
        int mid;
        int hit;
        logic signed [DATA_W-1:0] m;
        lo = 0;
        hi = model_count - 1;
        hit = -1;
        while (hit < 0 && lo <= hi) begin
            mid = lo + (hi - lo) / 2;
            m = model_words[mid];
            if (m == target) begin
                hit = mid;
            end else if (mid - 1 >= lo && model_words[mid-1] == target) begin
                hit = mid - 1;
            end else if (mid + 1 <= hi && model_words[mid+1] == target) begin
                hit = mid + 1;
            end else if (target > m) begin
                lo = mid + 2;
            end else begin
                hi = mid - 2;
            end
        end
        return hit;
    endfunction

    function automatic void apply_request(input logic [ACT_W-1:0] act,
                                          input logic signed [DATA_W-1:0] val);
        search_answer ans;
        int idx;
        case (act)
            ACT_APPEND: begin
                if (model_count < DEPTH) begin
                    model_words[model_count] = val;
                    model_count++;
                end else begin
                    model_overflow = 1'b1;
                end
            end
            ACT_CLEAR: model_count = 0;
            ACT_QUERY: begin
                idx = probe_search(val);
                ans.found = (idx >= 0);
                ans.position = (idx >= 0) ? POS_W'(idx) : '0;
                ans.overflowed = model_overflow;
                pending_answers.push_back(ans);
            end
            default: ;
        endcase
    endfunction

    function automatic int idle_share(input bit sender);
        if (n_taken < n_items / 3) return sender ? 36 : 47;
        if (n_taken < 2 * n_items / 3) return sender ? 47 : 36;
        return 0;
    endfunction

    task automatic push_req(input logic [ACT_W-1:0] act, input logic signed [DATA_W-1:0] val);
        stim_entry e;
        e.pause = 1'b0;
        e.action = act;
        e.value = val;
        stim_q.push_back(e);
        n_items++;
    endtask

    task automatic push_pause();
        stim_entry e;
        e.pause = 1'b1;
        e.action = ACT_APPEND;
        e.value = '0;
        stim_q.push_back(e);
    endtask

    // Appends n words, ascending with random gaps and then with some adjacent
    // pairs swapped; now and then the words are fully random instead.
    task automatic add_set(input int n);
        longint cur;
        longint step;
        int i;
        bit scramble;
        logic signed [DATA_W-1:0] tmp;
        gen_set.delete();
        scramble = ($urandom_range(0, 9) == 0);
        if ($urandom_range(0, 1) == 1) begin
            step = 64'd4294967295 / (n + 1);
            cur = -64'sd2147483648 + longint'($urandom_range(0, 32'(step)));
        end else begin
            step = 3;
            cur = longint'($urandom_range(0, 2000)) - 1000;
        end
        for (i = 0; i < n; i++) begin
            if (scramble) gen_set.push_back($urandom);
            else gen_set.push_back(DATA_W'(cur));
            cur += longint'($urandom_range(0, 32'(step)));
        end
        i = 0;
        while (i + 1 < n) begin
            if ($urandom_range(0, 99) < 30) begin
                tmp = gen_set[i];
                gen_set[i] = gen_set[i+1];
                gen_set[i+1] = tmp;
                i += 2;
            end else begin
                i++;
            end
        end
        foreach (gen_set[k]) push_req(ACT_APPEND, gen_set[k]);
    endtask

    task automatic add_queries(input int count);
        int j;
        logic signed [DATA_W-1:0] present;
        logic signed [DATA_W-1:0] t;
        for (j = 0; j < count; j++) begin
            if (gen_set.size() > 0) present = gen_set[$urandom_range(0, gen_set.size() - 1)];
            else present = $urandom;
            case ($urandom_range(0, 4))
                0, 1: t = present;
                2: t = ($urandom_range(0, 1) == 1) ? present + 1 : present - 1;
                3: t = $urandom;
                default: t = ($urandom_range(0, 1) == 1) ? WORD_MAX : WORD_MIN;
            endcase
            push_req(ACT_QUERY, t);
        end
    endtask

    task automatic add_round();
        if ($urandom_range(0, 6) != 0) push_req(ACT_CLEAR, $urandom);
        add_set($urandom_range(0, 40));
        if ($urandom_range(0, 9) == 0) push_req(ACT_UNUSED, $urandom);
        add_queries($urandom_range(1, 6));
    endtask

    // Request driver.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (!i_in_valid || in_fire) begin
            if (stim_q.size() == 0) begin
                i_in_valid <= 1'b0;
            end else if (stim_q[0].pause) begin
                // Hold off until every query already sent has been answered.
                i_in_valid <= 1'b0;
                if (pending_answers.size() == 0) void'(stim_q.pop_front());
            end else if ($urandom_range(0, 99) < idle_share(1'b1)) begin
                i_in_valid <= 1'b0;
            end else begin
                i_in_valid <= 1'b1;
                i_action <= stim_q[0].action;
                i_value <= stim_q[0].value;
                void'(stim_q.pop_front());
            end
        end
    end

    // Result receiver, with one long stall while queries keep coming in.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else if (hold_left > 0) begin
            i_out_ready <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (!hold_done && n_taken >= hold_mark) begin
            i_out_ready <= 1'b0;
            hold_left <= STALL_CYCLES;
            hold_done <= 1'b1;
        end else begin
            i_out_ready <= ($urandom_range(0, 99) >= idle_share(1'b0));
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_fire <= 1'b0;
        end else begin
            in_fire <= i_in_valid && o_in_ready;
            if (o_out_valid && i_out_ready) begin
                if (pending_answers.size() == 0) begin
                    $display("%0t: unexpected result found=%0b position=%0d overflowed=%0b",
                             $realtime, o_found, o_position, o_overflowed);
                    n_errors++;
                end else begin
                    oldest = pending_answers.pop_front();
                    if (o_found !== oldest.found) begin
                        $display("%0t: found mismatch, expected %0b, got %0b",
                                 $realtime, oldest.found, o_found);
                        n_errors++;
                    end
                    if (o_position !== oldest.position) begin
                        $display("%0t: position mismatch, expected %0d, got %0d",
                                 $realtime, oldest.position, o_position);
                        n_errors++;
                    end
                    if (o_overflowed !== oldest.overflowed) begin
                        $display("%0t: overflowed mismatch, expected %0b, got %0b",
                                 $realtime, oldest.overflowed, o_overflowed);
                        n_errors++;
                    end
                end
            end
            if (i_in_valid && o_in_ready) begin
                n_taken <= n_taken + 1;
                apply_request(i_action, i_value);
            end
        end
    end

    initial begin
        // Directed part: empty store, extremes, a swapped pair, misses, clear.
        push_req(ACT_QUERY, '0);
        push_req(ACT_UNUSED, -1);
        push_req(ACT_APPEND, WORD_MIN);
        push_req(ACT_APPEND, -5);
        push_req(ACT_APPEND, 0);
        push_req(ACT_APPEND, 3);
        push_req(ACT_APPEND, 2);
        push_req(ACT_APPEND, 9);
        push_req(ACT_APPEND, WORD_MAX);
        push_req(ACT_UNUSED, WORD_MAX);
        push_req(ACT_QUERY, WORD_MIN);
        push_req(ACT_QUERY, WORD_MAX);
        push_req(ACT_QUERY, 2);
        push_req(ACT_QUERY, 3);
        push_req(ACT_QUERY, 9);
        push_req(ACT_QUERY, 4);
        push_req(ACT_QUERY, WORD_MIN + 1);
        push_req(ACT_QUERY, WORD_MAX - 1);
        push_req(ACT_CLEAR, '0);
        push_req(ACT_QUERY, 9);
        push_req(ACT_APPEND, 42);
        push_req(ACT_QUERY, 42);
        push_req(ACT_QUERY, 41);

        while (n_items < 150) add_round();

        // Fill the store completely, push past capacity, then search it deep.
        push_pause();
        push_req(ACT_CLEAR, '0);
        add_set(DEPTH);
        repeat (3) push_req(ACT_APPEND, $urandom);
        hold_mark = n_items;
        add_queries(40);
        push_pause();

        while (n_items < 1270) add_round();

        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (stim_q.size() != 0 || i_in_valid) @(posedge i_clk);
        while (pending_answers.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (n_errors == 0) begin
            $display("PASS nearly_sorted_array_search_unit");
        end else begin
            $display("FAIL nearly_sorted_array_search_unit");
        end
        $finish;
    end

    initial begin
        #4ms;
        $display("%0t: timeout", $realtime);
        $display("FAIL nearly_sorted_array_search_unit");
        $finish;
    end

endmodule
